[sv/rslb_pkg.sv]
// ----------------------------------------------------------------------------
// rslb_pkg
// shared widths, register indexes and divider handshake types for the
// shift-light bar
// ----------------------------------------------------------------------------
package rslb_pkg;

  localparam int unsigned MAX_PIXELS = 64;

  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned DVD_W  = SPEED_W + COUNT_W;
  localparam int unsigned QUOT_W = COUNT_W;
  localparam int unsigned HALF_W = COUNT_W - 1;
  localparam int unsigned CNT_W  = $clog2(DVD_W);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 3'd5;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'h00;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [SPEED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/rslb_in_if.sv]
// ----------------------------------------------------------------------------
// rslb_in_if
// speed sample channel: valid/ready with speed and millisecond timestamp
// ----------------------------------------------------------------------------
interface rslb_in_if;
  logic                         valid;
  logic                         ready;
  logic [rslb_pkg::SPEED_W-1:0] speed;
  logic [rslb_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output speed, output now_ms, input ready);
  modport sink   (input valid, input speed, input now_ms, output ready);
endinterface

[sv/rslb_out_if.sv]
// ----------------------------------------------------------------------------
// rslb_out_if
// pixel channel: valid/ready with one pixel color and frame end flag per beat
// ----------------------------------------------------------------------------
interface rslb_out_if;
  logic                         valid;
  logic                         ready;
  logic [rslb_pkg::INDEX_W-1:0] pixel_index;
  logic [rslb_pkg::COLOR_W-1:0] red;
  logic [rslb_pkg::COLOR_W-1:0] green;
  logic [rslb_pkg::COLOR_W-1:0] blue;
  logic                         frame_last;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output frame_last, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input frame_last, output ready);
endinterface

[sv/rpm_shift_light_bar.sv]
// ----------------------------------------------------------------------------
// rpm_shift_light_bar
// engine speed shift-light bar: one speed sample in, one frame of pixels out
// ----------------------------------------------------------------------------
// normal sample: bar length from a bit-serial divide, then one pixel per cycle
//   while the sink is ready (for both kinds of sample)
// over-speed sample: blink check, then if a toggle is due one pixel per cycle
// one sample at a time; the next is taken once the last pixel is in the
//   output register, which may still wait for the sink
// rst is synchronous: registers return to their defaults, blink state clears
module rpm_shift_light_bar (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rslb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rslb_pkg::CFG_DAT_W-1:0]   cfg_data,
  rslb_in_if.sink                          sample,
  rslb_out_if.source                       pixel
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLINK,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                         state;

  // configuration
  logic                           enable;
  logic [rslb_pkg::SPEED_W-1:0]   speed_max;
  logic [rslb_pkg::SPEED_W-1:0]   green_limit;
  logic [rslb_pkg::SPEED_W-1:0]   yellow_limit;
  logic [rslb_pkg::COUNT_W-1:0]   pixel_count;
  logic [rslb_pkg::SPEED_W-1:0]   blink_interval;

  // blink state
  logic [rslb_pkg::TIME_W-1:0]    last_toggle_time;
  logic                           blink_on;

  // per-sample working registers
  logic [rslb_pkg::TIME_W-1:0]    elapsed;
  logic [rslb_pkg::TIME_W-1:0]    now_hold;
  logic [rslb_pkg::COLOR_W-1:0]   col_red;
  logic [rslb_pkg::COLOR_W-1:0]   col_green;
  logic [rslb_pkg::HALF_W-1:0]    half;
  logic [rslb_pkg::COUNT_W-1:0]   pix_i;

  // output register
  logic                           out_valid;
  logic [rslb_pkg::INDEX_W-1:0]   out_index;
  logic [rslb_pkg::COLOR_W-1:0]   out_red;
  logic [rslb_pkg::COLOR_W-1:0]   out_green;
  logic                           out_last;

  logic                           accept;
  logic                           over;
  logic [rslb_pkg::COUNT_W-1:0]   n_used;
  logic [rslb_pkg::COUNT_W-1:0]   n_last;
  logic [rslb_pkg::COUNT_W-1:0]   mirror;
  logic [rslb_pkg::COUNT_W-1:0]   end_dist;
  logic                           pix_lit;
  logic                           out_free;

  rslb_pkg::div_req_t             div_req;
  rslb_pkg::div_rsp_t             div_rsp;

  assign n_used = (pixel_count > rslb_pkg::COUNT_W'(rslb_pkg::MAX_PIXELS))
                  ? rslb_pkg::COUNT_W'(rslb_pkg::MAX_PIXELS) : pixel_count;
  assign n_last = n_used - 1'b1;

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign over         = (sample.speed > speed_max);

  assign div_req.start    = accept && enable && !over && (speed_max != '0);
  assign div_req.dividend = rslb_pkg::DVD_W'(sample.speed) * rslb_pkg::DVD_W'(n_used);
  assign div_req.divisor  = speed_max;

  rslb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // distance to the nearer end of the strip
  assign mirror   = n_last - pix_i;
  assign end_dist = (pix_i < mirror) ? pix_i : mirror;
  assign pix_lit  = (end_dist <= {1'b0, half});
  assign out_free = !out_valid || pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      enable           <= 1'b0;
      speed_max        <= 16'd10000;
      green_limit      <= 16'd6000;
      yellow_limit     <= 16'd8000;
      pixel_count      <= 7'd16;
      blink_interval   <= 16'd100;
      last_toggle_time <= '0;
      blink_on         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rslb_pkg::REG_ENABLE:    enable         <= cfg_data[0];
          rslb_pkg::REG_SPEED_MAX: speed_max      <= cfg_data;
          rslb_pkg::REG_GREEN:     green_limit    <= cfg_data;
          rslb_pkg::REG_YELLOW:    yellow_limit   <= cfg_data;
          rslb_pkg::REG_PIXELS:    pixel_count    <= cfg_data[rslb_pkg::COUNT_W-1:0];
          rslb_pkg::REG_BLINK:     blink_interval <= cfg_data;
          default: ;
        endcase
      end

      // while emitting, the output register is refilled below
      if (pixel.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && enable) begin
            pix_i <= '0;
            if (over) begin
              elapsed  <= sample.now_ms - last_toggle_time;
              now_hold <= sample.now_ms;
              state    <= S_BLINK;
            end else begin
              priority if (sample.speed < green_limit) begin
                col_red   <= rslb_pkg::COLOR_OFF;
                col_green <= rslb_pkg::COLOR_FULL;
              end else if (sample.speed < yellow_limit) begin
                col_red   <= rslb_pkg::COLOR_FULL;
                col_green <= rslb_pkg::COLOR_FULL;
              end else begin
                col_red   <= rslb_pkg::COLOR_FULL;
                col_green <= rslb_pkg::COLOR_OFF;
              end
              if (speed_max == '0) begin
                // only speed zero gets here: full bar
                half  <= n_used[rslb_pkg::COUNT_W-1:1];
                state <= (n_used == '0) ? S_IDLE : S_EMIT;
              end else begin
                state <= S_DIV;
              end
            end
          end
        end

        S_BLINK: begin
          if (elapsed < rslb_pkg::TIME_W'(blink_interval)) begin
            state <= S_IDLE;
          end else begin
            last_toggle_time <= now_hold;
            blink_on         <= !blink_on;
            col_red          <= blink_on ? rslb_pkg::COLOR_OFF : rslb_pkg::COLOR_FULL;
            col_green        <= rslb_pkg::COLOR_OFF;
            // every pixel lit
            half             <= '1;
            state            <= (n_used == '0) ? S_IDLE : S_EMIT;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            half  <= div_rsp.quotient[rslb_pkg::QUOT_W-1:1];
            state <= (n_used == '0) ? S_IDLE : S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_index <= pix_i[rslb_pkg::INDEX_W-1:0];
            out_red   <= pix_lit ? col_red : rslb_pkg::COLOR_OFF;
            out_green <= pix_lit ? col_green : rslb_pkg::COLOR_OFF;
            out_last  <= (pix_i == n_last);
            pix_i     <= pix_i + 1'b1;
            if (pix_i == n_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.red         = out_red;
  assign pixel.green       = out_green;
  assign pixel.blue        = rslb_pkg::COLOR_OFF;
  assign pixel.frame_last  = out_last;

endmodule

[sv/rslb_div.sv]
// ----------------------------------------------------------------------------
// rslb_div
// bit-serial restoring divider, one quotient bit per cycle, dividend shifted
// in msb first
// ----------------------------------------------------------------------------
module rslb_div (
  input  logic               clk,
  input  logic               rst,
  input  rslb_pkg::div_req_t req,
  output rslb_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic [rslb_pkg::CNT_W-1:0]       cnt;
  logic [rslb_pkg::DVD_W-1:0]       dvd;
  logic [rslb_pkg::SPEED_W-1:0]     divisor;
  logic [rslb_pkg::SPEED_W-1:0]     rem;
  logic [rslb_pkg::QUOT_W-1:0]      quot;
  logic                             done;

  logic [rslb_pkg::SPEED_W:0]       trial;
  logic [rslb_pkg::SPEED_W:0]       diff;
  logic                             qbit;

  // shift next dividend bit into the partial remainder and try the subtract
  assign trial = {rem, dvd[rslb_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy    <= 1'b1;
        done    <= 1'b0;
        cnt     <= rslb_pkg::CNT_W'(rslb_pkg::DVD_W - 1);
        dvd     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        quot    <= '0;
      end else if (busy) begin
        dvd  <= {dvd[rslb_pkg::DVD_W-2:0], 1'b0};
        rem  <= qbit ? diff[rslb_pkg::SPEED_W-1:0] : trial[rslb_pkg::SPEED_W-1:0];
        quot <= {quot[rslb_pkg::QUOT_W-2:0], qbit};
        cnt  <= cnt - 1'b1;
        done <= (cnt == '0);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule
